// ===== rtl/core/vwim_pkg.sv =====
// vwim_pkg: shared types and constants of the vertex weld index map.
// Holds the item and result structs, the command code and the table sizes.
// Has no dependencies.
package vwim_pkg;

	localparam int MAX_POINTS = 4096;
	localparam int MAX_UNIQUE = 4096;
	localparam int PT_AW      = $clog2(MAX_POINTS);
	localparam int UQ_AW      = $clog2(MAX_UNIQUE);
	localparam int PC_W       = $clog2(MAX_POINTS + 1);
	localparam int UC_W       = $clog2(MAX_UNIQUE + 1);
	localparam int IDX_W      = 12;

	localparam logic [63:0] TOL_RESET = 64'd4295;

	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_ADD   = 2'd1;
	localparam logic [1:0] ACT_REMAP = 2'd2;
	localparam logic [1:0] ACT_NONE  = 2'd3;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_ADD,
		OP_REMAP,
		OP_NOP
	} cmd_op_t;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [31:0] x_coord;
		logic signed [31:0] y_coord;
		logic signed [31:0] z_coord;
		logic [11:0]        corner_index;
	} in_item_t;

	typedef struct packed {
		logic [11:0] merged_index;
		logic        is_new;
		logic        store_full;
		logic        bad_index;
	} out_item_t;

	typedef struct packed {
		cmd_op_t            op;
		logic signed [31:0] x_coord;
		logic signed [31:0] y_coord;
		logic signed [31:0] z_coord;
		logic [11:0]        corner_index;
	} cmd_t;

	typedef struct packed {
		logic [UC_W-1:0] unique_count;
		logic [PC_W-1:0] point_count;
	} stat_t;

endpackage

// ===== rtl/core/vwim_front.sv =====
// vwim_front: input side, decodes each item into a command and queues it.
// Two-entry queue toward the back end. Depends on vwim_pkg.
module vwim_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  vwim_pkg::in_item_t item,
	output logic              cmd_valid,
	output vwim_pkg::cmd_t    cmd,
	input  logic              cmd_pop
);

	vwim_pkg::cmd_t slot_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	vwim_pkg::cmd_t dec;
	logic           do_push;
	logic           do_pop;

	// classify the action code
	always_comb begin
		dec.x_coord      = item.x_coord;
		dec.y_coord      = item.y_coord;
		dec.z_coord      = item.z_coord;
		dec.corner_index = item.corner_index;
		unique case (item.action)
			vwim_pkg::ACT_CLEAR: dec.op = vwim_pkg::OP_CLEAR;
			vwim_pkg::ACT_ADD:   dec.op = vwim_pkg::OP_ADD;
			vwim_pkg::ACT_REMAP: dec.op = vwim_pkg::OP_REMAP;
			vwim_pkg::ACT_NONE:  dec.op = vwim_pkg::OP_NOP;
		endcase
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

// ===== rtl/core/vwim_back.sv =====
// vwim_back: executes commands against the point tables.
// Holds the unique point and index map memories, the scan pipeline and the
// result register. Depends on vwim_pkg.
module vwim_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [63:0]        tol,
	input  logic               cmd_valid,
	input  vwim_pkg::cmd_t     cmd,
	output logic               cmd_pop,
	output logic               res_valid,
	output vwim_pkg::out_item_t res,
	input  logic               res_pop,
	output vwim_pkg::stat_t    stat
);

	localparam int UW = vwim_pkg::UQ_AW;
	localparam int PW = vwim_pkg::PT_AW;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_REMAP
	} state_t;

	logic [31:0] mem_x [vwim_pkg::MAX_UNIQUE];
	logic [31:0] mem_y [vwim_pkg::MAX_UNIQUE];
	logic [31:0] mem_z [vwim_pkg::MAX_UNIQUE];
	logic [PW-1:0] mem_map [vwim_pkg::MAX_POINTS];

	state_t                   state_q;
	vwim_pkg::cmd_t           cur_q;
	logic [vwim_pkg::UC_W-1:0] uc_q;
	logic [vwim_pkg::PC_W-1:0] pc_q;
	logic [vwim_pkg::UC_W-1:0] iss_q;
	logic                     found_q;
	logic [UW-1:0]            hit_q;
	logic                     out_valid_q;
	vwim_pkg::out_item_t      out_q;
	logic [PW-1:0]            map_rd_q;

	logic v_s1, v_s2, v_s3, v_s4;
	logic [UW-1:0] idx_s1, idx_s2, idx_s3, idx_s4;
	logic [31:0] ux_s1, uy_s1, uz_s1;
	logic [31:0] mx_s2, my_s2, mz_s2;
	logic [63:0] sx_s3, sy_s3, sz_s3;
	logic [63:0] sxy_s4, sz_s4;

	logic          take;
	logic          issue;
	logic          hit4;
	logic [64:0]   sum4;
	logic [63:0]   dist4;
	logic [64:0]   sum3;
	logic          drained;
	logic          uq_room;
	logic          wr_uq;
	logic          wr_map;
	logic [UW-1:0] wr_idx;
	logic [PW-1:0] map_raddr;

	function automatic logic [31:0] abs_diff(logic [31:0] a, logic [31:0] b);
		logic [32:0] d;
		logic [32:0] n;
		d = {a[31], a} - {b[31], b};
		n = -d;
		return d[32] ? n[31:0] : d[31:0];
	endfunction

	assign take      = (state_q == ST_IDLE) && cmd_valid && !out_valid_q;
	assign cmd_pop   = take;
	assign issue     = (state_q == ST_SCAN) && (iss_q < uc_q);
	assign sum4      = {1'b0, sxy_s4} + {1'b0, sz_s4};
	assign dist4     = sum4[64] ? '1 : sum4[63:0];
	assign hit4      = (state_q == ST_SCAN) && v_s4 && (dist4 < tol);
	assign sum3      = {1'b0, sx_s3} + {1'b0, sy_s3};
	assign drained   = !v_s1 && !v_s2 && !v_s3 && !v_s4 && (iss_q == uc_q);
	assign uq_room   = (uc_q != vwim_pkg::UC_W'(vwim_pkg::MAX_UNIQUE));
	assign wr_uq     = (state_q == ST_DECIDE) && !found_q && uq_room;
	assign wr_map    = (state_q == ST_DECIDE) && (found_q || uq_room);
	assign wr_idx    = found_q ? hit_q : uc_q[UW-1:0];
	assign map_raddr = PW'(cmd.corner_index);

	// memories: one write port, one registered read port each
	always_ff @(posedge clk) begin
		if (wr_uq) begin
			mem_x[uc_q[UW-1:0]] <= cur_q.x_coord;
			mem_y[uc_q[UW-1:0]] <= cur_q.y_coord;
			mem_z[uc_q[UW-1:0]] <= cur_q.z_coord;
		end
		ux_s1 <= mem_x[iss_q[UW-1:0]];
		uy_s1 <= mem_y[iss_q[UW-1:0]];
		uz_s1 <= mem_z[iss_q[UW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (wr_map) begin
			mem_map[pc_q[PW-1:0]] <= wr_idx;
		end
		map_rd_q <= mem_map[map_raddr];
	end

	// distance pipeline payload
	always_ff @(posedge clk) begin
		idx_s1 <= iss_q[UW-1:0];
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		idx_s4 <= idx_s3;
		mx_s2  <= abs_diff(cur_q.x_coord, ux_s1);
		my_s2  <= abs_diff(cur_q.y_coord, uy_s1);
		mz_s2  <= abs_diff(cur_q.z_coord, uz_s1);
		sx_s3  <= mx_s2 * mx_s2;
		sy_s3  <= my_s2 * my_s2;
		sz_s3  <= mz_s2 * mz_s2;
		sxy_s4 <= sum3[64] ? '1 : sum3[63:0];
		sz_s4  <= sz_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			uc_q        <= '0;
			pc_q        <= '0;
			iss_q       <= '0;
			found_q     <= 1'b0;
			hit_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			cur_q       <= '0;
		end else begin
			if (res_pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			v_s1 <= issue && !hit4;
			v_s2 <= v_s1 && !hit4;
			v_s3 <= v_s2 && !hit4;
			v_s4 <= v_s3 && !hit4;
			if (issue) begin
				iss_q <= iss_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						cur_q <= cmd;
						iss_q <= '0;
						found_q <= 1'b0;
						unique case (cmd.op)
							vwim_pkg::OP_CLEAR: begin
								uc_q        <= '0;
								pc_q        <= '0;
								out_q       <= '0;
								out_valid_q <= 1'b1;
							end
							vwim_pkg::OP_ADD: begin
								if (pc_q == vwim_pkg::PC_W'(vwim_pkg::MAX_POINTS)) begin
									out_q       <= '{merged_index: '0, is_new: 1'b0,
										store_full: 1'b1, bad_index: 1'b0};
									out_valid_q <= 1'b1;
								end else if (uc_q == '0) begin
									state_q <= ST_DECIDE;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							vwim_pkg::OP_REMAP: begin
								if (32'(cmd.corner_index) < 32'(pc_q)) begin
									state_q <= ST_REMAP;
								end else begin
									out_q       <= '{merged_index: '0, is_new: 1'b0,
										store_full: 1'b0, bad_index: 1'b1};
									out_valid_q <= 1'b1;
								end
							end
							vwim_pkg::OP_NOP: begin
								out_q       <= '0;
								out_valid_q <= 1'b1;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (hit4) begin
						found_q <= 1'b1;
						hit_q   <= idx_s4;
						state_q <= ST_DECIDE;
					end else if (drained) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (found_q) begin
						out_q <= '{merged_index: vwim_pkg::IDX_W'(hit_q), is_new: 1'b0,
							store_full: 1'b0, bad_index: 1'b0};
						pc_q <= pc_q + 1'b1;
					end else if (uq_room) begin
						out_q <= '{merged_index: vwim_pkg::IDX_W'(uc_q[UW-1:0]),
							is_new: 1'b1, store_full: 1'b0, bad_index: 1'b0};
						uc_q <= uc_q + 1'b1;
						pc_q <= pc_q + 1'b1;
					end else begin
						out_q <= '{merged_index: '0, is_new: 1'b0,
							store_full: 1'b1, bad_index: 1'b0};
					end
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_REMAP: begin
					out_q       <= '{merged_index: vwim_pkg::IDX_W'(map_rd_q), is_new: 1'b0,
						store_full: 1'b0, bad_index: 1'b0};
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid         = out_valid_q;
	assign res               = out_q;
	assign stat.unique_count = uc_q;
	assign stat.point_count  = pc_q;

endmodule

// ===== rtl/core/vertex_weld_index_map_top.sv =====
// vertex_weld_index_map_top: top level of the vertex weld index map.
// Instantiates vwim_front and vwim_back and holds the tolerance register.
// Depends on vwim_pkg, vwim_front, vwim_back.
//
// Usage:
//   Input channel: drive item and raise push; a beat is taken at a clock edge
//   with push high and full low. A two-entry command queue sits in front of
//   the execution engine, so items are taken while earlier ones still run.
//   Result channel: while empty is low, result holds the oldest result; raise
//   pop to take it. Every item gives exactly one result beat, in order.
//   Configuration: cfg_data carries tolerance_squared; a beat is written at an
//   edge with cfg_valid and cfg_ready high. cfg_ready is always high. Write
//   only while no item is in flight.
// Steps per item, one item at a time; the engine takes a new item only once
// the result register is empty, so items run one after another:
//   clear, no-op, rejected add, unknown remap: result written on acceptance.
//   remap of a known index: registered index map read, then the result.
//   add with no stored point: straight to the decide state, then the result.
//   add: the scan reads one stored point per cycle through a 4-stage
//   distance pipeline (read, difference, square, sum) until the first stored
//   point matches or all are scanned and the pipeline is empty; then the
//   decide state writes the result. The scan covers up to 4096 stored points.
// Reset: arst_n clears counts, queue and result register; tolerance returns to
//   4295. The point memories are not cleared; only entries below the counts are used.
// Receiver stall: the result register holds its beat; the engine waits and the
//   queue fills, then full rises and holds off the sender.
module vertex_weld_index_map_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  vwim_pkg::in_item_t  item,
	output logic                empty,
	input  logic                pop,
	output vwim_pkg::out_item_t result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [63:0]         cfg_data
);

	logic [63:0]     tol_q;
	logic            cmd_valid;
	vwim_pkg::cmd_t  cmd;
	logic            cmd_pop;
	logic            res_valid;
	vwim_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	// hold the tolerance until the next config beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= vwim_pkg::TOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tol_q <= cfg_data;
		end
	end

	vwim_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	vwim_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tol       (tol_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_valid (res_valid),
		.res       (result),
		.res_pop   (pop),
		.stat      (stat)
	);

	assign empty = !res_valid;

	// merged points never outnumber added points
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(stat.unique_count) <= 32'(stat.point_count))
	else $error("unique count exceeds point count");

	// a new point is never also flagged as rejected or bad
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.is_new) |-> (!result.store_full && !result.bad_index))
	else $error("new point carries an error flag");

	// flagged results carry merged index zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (result.store_full || result.bad_index)) |-> (result.merged_index == 12'd0))
	else $error("flagged result has nonzero index");

	// an unpopped result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
	else $error("waiting result changed");

endmodule

// ===== tb/vwim_scoreboard.sv =====
// vwim_scoreboard: tracks the vertex weld index map. It keeps its own copy of the
// point tables, predicts each result beat and compares it with the block's output.
// Depends on vwim_pkg.
module vwim_scoreboard (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                full,
	input  vwim_pkg::in_item_t  item,
	input  logic                empty,
	input  logic                pop,
	input  vwim_pkg::out_item_t result,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [63:0]         cfg_data,
	output int                  fail_count,
	output int                  pending
);
	import vwim_pkg::*;

	logic signed [31:0] pts_x [MAX_UNIQUE];
	logic signed [31:0] pts_y [MAX_UNIQUE];
	logic signed [31:0] pts_z [MAX_UNIQUE];
	logic [11:0]        weld_map [MAX_POINTS];
	int                 n_unique;
	int                 n_points;
	logic [63:0]        tol_sq;
	out_item_t          welds_due [$];

	// Squared distance, saturating at all ones.
	function automatic logic [63:0] dist_sq(logic signed [31:0] ax, logic signed [31:0] ay,
			logic signed [31:0] az, int k);
		longint            d [3];
		logic [63:0]       m;
		logic [64:0]       acc;
		d[0] = longint'(ax) - longint'(pts_x[k]);
		d[1] = longint'(ay) - longint'(pts_y[k]);
		d[2] = longint'(az) - longint'(pts_z[k]);
		acc = '0;
		for (int i = 0; i < 3; i++) begin
			m = (d[i] < 0) ? 64'(-d[i]) : 64'(d[i]);
			acc = acc + 65'(m * m);
			if (acc[64])
				acc = {1'b0, {64{1'b1}}};
		end
		return acc[63:0];
	endfunction

	function automatic out_item_t weld_predict(in_item_t it);
		out_item_t r;
		cmd_op_t   op;
		bit        hit;
		int        at;
		r = '0;
		hit = 0;
		at = 0;
		op = cmd_op_t'(it.action);
		case (op)
			OP_CLEAR: begin
				n_unique = 0;
				n_points = 0;
			end
			OP_ADD: begin
				for (int k = 0; k < n_unique; k++) begin
					if (dist_sq(it.x_coord, it.y_coord, it.z_coord, k) < tol_sq) begin
						hit = 1;
						at = k;
						break;
					end
				end
				if (n_points >= MAX_POINTS || (!hit && n_unique >= MAX_UNIQUE)) begin
					r.store_full = 1'b1;
				end else begin
					if (!hit) begin
						at = n_unique;
						pts_x[at] = it.x_coord;
						pts_y[at] = it.y_coord;
						pts_z[at] = it.z_coord;
						n_unique++;
						r.is_new = 1'b1;
					end
					weld_map[n_points] = 12'(at);
					n_points++;
					r.merged_index = 12'(at);
				end
			end
			OP_REMAP: begin
				if (int'(it.corner_index) < n_points)
					r.merged_index = weld_map[it.corner_index];
				else
					r.bad_index = 1'b1;
			end
			default: ;
		endcase
		return r;
	endfunction

	assign pending = welds_due.size();

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			n_unique = 0;
			n_points = 0;
			tol_sq = TOL_RESET;
			fail_count = 0;
			welds_due.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				tol_sq = cfg_data;
			if (pop && !empty) begin
				if (welds_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result beat: idx %0d new %b full %b bad %b",
							result.merged_index, result.is_new, result.store_full,
							result.bad_index);
				end else begin
					want = welds_due.pop_front();
					if (result.merged_index !== want.merged_index
							|| result.is_new !== want.is_new
							|| result.store_full !== want.store_full
							|| result.bad_index !== want.bad_index) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: exp %0d/%b/%b/%b got %0d/%b/%b/%b",
								want.merged_index, want.is_new, want.store_full,
								want.bad_index, result.merged_index, result.is_new,
								result.store_full, result.bad_index);
					end
				end
			end
			if (push && !full)
				welds_due.insert(welds_due.size(), weld_predict(item));
		end
	end

endmodule

// ===== tb/tb_vertex_weld_index_map_top.sv =====
// tb_vertex_weld_index_map_top: stimulus and verdict for the vertex weld index map.
// Drives item, result and tolerance channels; vwim_scoreboard does the checking.
// Depends on vwim_pkg, vertex_weld_index_map_top and vwim_scoreboard.
module tb_vertex_weld_index_map_top;
	import vwim_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	in_item_t    item;
	logic        empty;
	logic        pop;
	out_item_t   result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [63:0] cfg_data;
	int          fail_count;
	int          pending;

	// Idle and stall rates in percent, changed per phase.
	int          send_idle_pct;
	int          recv_stall_pct;
	logic        hold_go;
	int          hold_left;
	int          cycles;

	// Recent added points; half of the random adds land near them so that merges happen.
	logic signed [31:0] near_x [8];
	logic signed [31:0] near_y [8];
	logic signed [31:0] near_z [8];

	vertex_weld_index_map_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	vwim_scoreboard scb (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.empty      (empty),
		.pop        (pop),
		.result     (result),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Result side: a hold-off request stops popping for a long stretch; otherwise
	// stall at the phase rate.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			hold_left <= 0;
		end else if (hold_go) begin
			hold_left <= 400;
			pop <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("vertex_weld_index_map_top: mismatch");
			$finish;
		end
	end

	// Offer one beat and hold it until the block takes it. Push stays high
	// when the next beat follows directly.
	task automatic send_item(in_item_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		item <= it;
		push <= 1'b1;
		do
			@(posedge clk);
		while (full);
		if (it.action == OP_ADD) begin
			near_x[$urandom_range(7)] = it.x_coord;
			near_y[$urandom_range(7)] = it.y_coord;
			near_z[$urandom_range(7)] = it.z_coord;
		end
	endtask

	// Write the tolerance only once the block has drained.
	task automatic set_tolerance(logic [63:0] v);
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic in_item_t pt(cmd_op_t op, int x, int y, int z, int ci);
		in_item_t it;
		it.action = op;
		it.x_coord = x;
		it.y_coord = y;
		it.z_coord = z;
		it.corner_index = 12'(ci);
		return it;
	endfunction

	function automatic logic signed [31:0] jitter(logic signed [31:0] base);
		return base + $signed(32'($urandom_range(0, 160))) - 32'sd80;
	endfunction

	function automatic logic signed [31:0] coord_any();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed(32'($urandom_range(0, 4000))) - 32'sd2000;
		endcase
	endfunction

	// Mostly adds near known points with random content, some remaps, rare
	// clears and no-ops.
	function automatic in_item_t random_item();
		in_item_t it;
		int       w;
		int       k;
		w = $urandom_range(99);
		k = $urandom_range(7);
		it = '0;
		it.corner_index = $urandom_range(3) == 0 ? 12'($urandom) : 12'($urandom_range(0, 30));
		it.x_coord = $urandom;
		it.y_coord = $urandom;
		it.z_coord = $urandom;
		if (w < 60) begin
			it.action = OP_ADD;
			if ($urandom_range(1)) begin
				it.x_coord = jitter(near_x[k]);
				it.y_coord = jitter(near_y[k]);
				it.z_coord = jitter(near_z[k]);
			end else begin
				it.x_coord = coord_any();
				it.y_coord = coord_any();
				it.z_coord = coord_any();
			end
		end else if (w < 90) begin
			it.action = OP_REMAP;
		end else if (w < 94) begin
			it.action = OP_CLEAR;
		end else begin
			it.action = OP_NOP;
		end
		return it;
	endfunction

	task automatic random_phase(int n, int idle_pct, int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (n) send_item(random_item());
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		hold_go = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < 8; i++) begin
			near_x[i] = 0;
			near_y[i] = 0;
			near_z[i] = 0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, merge boundary, saturation, every action.
		send_item(pt(OP_REMAP, 0, 0, 0, 0));             // unknown index on empty map
		send_item(pt(OP_ADD, 0, 0, 0, 0));               // first point is new
		send_item(pt(OP_ADD, 65, 0, 0, 0));              // 65^2 below reset tolerance
		send_item(pt(OP_ADD, 0, 66, 0, 0));              // 66^2 above it: new point
		send_item(pt(OP_ADD, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0));
		send_item(pt(OP_ADD, 32'h80000000, 32'h80000000, 32'h80000000, 0));
		send_item(pt(OP_ADD, 32'h80000000, 32'h80000000, 32'h80000000, 0));
		send_item(pt(OP_ADD, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0));
		send_item(pt(OP_REMAP, 0, 0, 0, 1));
		send_item(pt(OP_REMAP, 0, 0, 0, 6));
		send_item(pt(OP_REMAP, 0, 0, 0, 7));             // one past the last point
		send_item(pt(OP_REMAP, 32'hffffffff, 32'hffffffff, 32'hffffffff, 4095));
		send_item(pt(OP_NOP, 32'h12345678, 0, 0, 5));
		send_item(pt(OP_CLEAR, 0, 0, 0, 0));
		send_item(pt(OP_REMAP, 0, 0, 0, 0));             // cleared map
		send_item(pt(OP_ADD, 100, -100, 7, 0));

		// Zero tolerance: nothing merges. Open with a long receiver hold-off so
		// the queue fills and full backs up the sender.
		set_tolerance(64'd0);
		hold_go <= 1'b1;
		@(posedge clk);
		hold_go <= 1'b0;
		random_phase(31, 0, 0);

		set_tolerance(64'hffff_ffff_ffff_ffff);
		random_phase(31, 56, 0);

		set_tolerance(64'd1 << 40);
		random_phase(31, 0, 56);

		set_tolerance(64'd4295);
		random_phase(31, 32, 32);

		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_item(pt(OP_REMAP, 0, 0, 0, 4095));
		send_item(pt(OP_CLEAR, 0, 0, 0, 0));
		send_item(pt(OP_ADD, 1, 2, 3, 0));
		push <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("vertex_weld_index_map_top: match");
		else
			$display("vertex_weld_index_map_top: mismatch");
		$finish;
	end

endmodule
